// File: hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the software timer table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int SLOT_W          = 3;
  localparam int TAG_W           = 8;
  localparam int DUR_W           = 31;

  localparam logic [DUR_W-1:0] NO_DEADLINE = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_CREATED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic [DUR_W-1:0]  duration;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] out_slot;
    logic [TAG_W-1:0]  out_tag;
    logic              last;
  } out_item_t;

  // Broadcast command to the cells, qualified per cell by a select bit
  typedef struct packed {
    logic             create;
    logic             start;
    logic             stop;
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] duration;
  } cmd_t;

  // Sweep controls shared by every cell
  typedef struct packed {
    logic             advance;
    logic             charge;
    logic [DUR_W-1:0] elapsed;
  } sweep_t;

  // Token passed along the chain while rescheduling
  typedef struct packed {
    logic             vld;
    logic             pend;
    logic [DUR_W-1:0] minimum;
  } wave_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } expire_t;

endpackage

// File: hw/rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// One timer slot: running mark, remaining count and tag, plus one stage of
// the reschedule chain.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            sel,
  input  sst_pkg::cmd_t   cmd,
  input  sst_pkg::sweep_t sweep,
  input  sst_pkg::wave_t  wave_in,
  output sst_pkg::wave_t  wave_out,
  output sst_pkg::expire_t expire
);
  import sst_pkg::*;

  logic             created_r;
  logic             run_r;
  logic [DUR_W-1:0] rem_r;
  logic [TAG_W-1:0] tag_r;
  wave_t            wave_r;
  wave_t            wave_nxt;

  logic             live;
  logic             survive;
  logic [DUR_W-1:0] left;

  always_comb begin
    live = created_r && run_r;
    if (sweep.charge) begin
      survive = rem_r > sweep.elapsed;
      left    = rem_r - sweep.elapsed;
    end else begin
      survive = rem_r != '0;
      left    = rem_r;
    end

    wave_nxt = wave_in;
    if (wave_in.vld && live && survive && (wave_in.minimum >= left)) begin
      wave_nxt.minimum = left;
      wave_nxt.pend    = 1'b1;
    end

    expire.vld  = wave_in.vld && live && !survive;
    expire.slot = expire.vld ? SLOT_W'(CELL_IDX) : '0;
    expire.tag  = expire.vld ? tag_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r  <= 1'b0;
      run_r      <= 1'b0;
      wave_r.vld <= 1'b0;
    end else begin
      if (sweep.advance) begin
        wave_r <= wave_nxt;
        if (wave_in.vld && live) begin
          if (survive) begin
            rem_r <= left;
          end else begin
            rem_r <= '0;
            run_r <= 1'b0;
          end
        end
      end
      if (sel && cmd.create) begin
        created_r <= 1'b1;
        run_r     <= 1'b0;
        tag_r     <= cmd.tag;
      end
      if (sel && cmd.start) begin
        run_r <= 1'b1;
        rem_r <= cmd.duration;
      end
      if (sel && cmd.stop) begin
        run_r <= 1'b0;
      end
    end
  end

  assign wave_out = wave_r;

endmodule

// File: hw/rtl/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// Action decode, tick counting, sweep launch and result buffering.
// ----------------------------------------------------------------------------
module sst_ctrl #(
  parameter int TIMER_SLOTS = sst_pkg::TIMER_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sst_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sst_pkg::out_item_t     out_data,
  output logic [TIMER_SLOTS-1:0] sel,
  output sst_pkg::cmd_t          cmd,
  output sst_pkg::sweep_t        sweep,
  output sst_pkg::wave_t         head,
  input  sst_pkg::wave_t         tail,
  input  sst_pkg::expire_t       expire
);
  import sst_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DUR_W-1:0] elapsed_r;
  logic [DUR_W-1:0] nearest_r;
  logic             pending_r;
  logic             charge_r;
  logic             head_vld_r;
  logic             hold_vld_r;
  out_item_t        hold_r;
  logic             out_vld_r;
  out_item_t        out_r;

  logic             accept;
  logic             full;
  logic             slot_ok;
  logic             out_free;
  logic             advance;
  logic             out_load;
  logic [DUR_W-1:0] elapsed_inc;

  always_comb begin
    accept      = in_valid && (state_r == ST_IDLE);
    full        = cnt_r == CNT_W'(TIMER_SLOTS);
    slot_ok     = int'(in_data.slot) < TIMER_SLOTS;
    out_free    = !out_vld_r || out_ready;
    advance     = !(expire.vld && hold_vld_r && !out_free);
    out_load    = ((state_r == ST_SWEEP) && expire.vld && advance && hold_vld_r) ||
                  ((state_r == ST_FINISH) && out_free);
    elapsed_inc = elapsed_r + 1'b1;

    cmd.create   = accept && (in_data.action == ACT_CREATE) && !full;
    cmd.start    = accept && (in_data.action == ACT_START);
    cmd.stop     = accept && (in_data.action == ACT_STOP);
    cmd.tag      = in_data.tag;
    cmd.duration = in_data.duration;

    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (in_data.action == ACT_CREATE) begin
        sel[i] = cnt_r == CNT_W'(i);
      end else begin
        sel[i] = int'(in_data.slot) == i;
      end
    end

    sweep.advance = advance;
    sweep.charge  = charge_r;
    sweep.elapsed = elapsed_r;

    head.vld     = head_vld_r;
    head.pend    = 1'b0;
    head.minimum = NO_DEADLINE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      elapsed_r  <= '0;
      nearest_r  <= '0;
      pending_r  <= 1'b0;
      charge_r   <= 1'b0;
      head_vld_r <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.action)
              ACT_CREATE: begin
                if (full) begin
                  hold_r <= '{kind: KIND_FULL, out_slot: '0, out_tag: '0, last: 1'b0};
                end else begin
                  hold_r <= '{kind: KIND_CREATED, out_slot: SLOT_W'(cnt_r),
                              out_tag: '0, last: 1'b0};
                  cnt_r  <= cnt_r + 1'b1;
                end
                hold_vld_r <= 1'b1;
                state_r    <= ST_FINISH;
              end
              ACT_START: begin
                if (slot_ok) begin
                  charge_r   <= 1'b0;
                  head_vld_r <= 1'b1;
                  state_r    <= ST_SWEEP;
                end
              end
              ACT_TICK: begin
                if (pending_r) begin
                  elapsed_r <= elapsed_inc;
                  if (elapsed_inc >= nearest_r) begin
                    charge_r   <= 1'b1;
                    head_vld_r <= 1'b1;
                    state_r    <= ST_SWEEP;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (advance) begin
            head_vld_r <= 1'b0;
          end
          if (expire.vld && advance) begin
            if (hold_vld_r) begin
              out_r <= hold_r;
            end
            hold_r     <= '{kind: KIND_EXPIRED, out_slot: expire.slot,
                            out_tag: expire.tag, last: 1'b0};
            hold_vld_r <= 1'b1;
          end
          if (tail.vld) begin
            nearest_r <= tail.minimum;
            pending_r <= tail.pend;
            elapsed_r <= '0;
            state_r   <= hold_vld_r ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_r      <= '{kind: hold_r.kind, out_slot: hold_r.out_slot,
                            out_tag: hold_r.out_tag, last: 1'b1};
            hold_vld_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/software_timer_table_core.sv
// ----------------------------------------------------------------------------
// software_timer_table_core
// Table of one-shot timers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one action per transfer:
// create, start, stop or a time-base tick. Result channel
// (out_valid/out_ready/out_data) returns create acknowledgements and timer
// expiries in ascending slot order, with last set on the final result of an
// action.
// Stop, and a tick that does not reach the nearest deadline, are handled in idle;
// create moves on to a finish state that places its result.
// A start on a valid slot, or a tick that reaches the deadline, sends a token
// down the chain of TIMER_SLOTS cells, one cell per cycle while the receiver
// does not stall; a finish state then releases the final result, if any.
// Results are staged in a holding register and an output register; while the
// receiver stalls, the token waits at a cell that has a further expiry.
// in_ready is low while an action is being worked on.
// Reset clears all running marks and the created count.
// ----------------------------------------------------------------------------
module software_timer_table_core #(
  parameter int TIMER_SLOTS = sst_pkg::TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::out_item_t out_data
);
  import sst_pkg::*;

  logic [TIMER_SLOTS-1:0] sel;
  cmd_t                   cmd;
  sweep_t                 sweep;
  wave_t                  wave_link [TIMER_SLOTS+1];
  expire_t                exp_cell  [TIMER_SLOTS];
  expire_t                exp_any;

  sst_ctrl #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .sel      (sel),
    .cmd      (cmd),
    .sweep    (sweep),
    .head     (wave_link[0]),
    .tail     (wave_link[TIMER_SLOTS]),
    .expire   (exp_any)
  );

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    sst_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .sel     (sel[i]),
      .cmd     (cmd),
      .sweep   (sweep),
      .wave_in (wave_link[i]),
      .wave_out(wave_link[i+1]),
      .expire  (exp_cell[i])
    );
  end

  always_comb begin
    exp_any = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      exp_any = expire_t'(exp_any | exp_cell[i]);
    end
  end

endmodule

// File: hw/rtl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks for the software timer table, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sst_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sst_pkg::out_item_t out_data
);
  import sst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_create_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_CREATE) |=> !in_ready)
    else $error("create did not hold off the input");

  a_create_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_EXPIRED) |-> out_data.last && (out_data.out_tag == '0))
    else $error("create result malformed");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_FULL) |-> (out_data.out_slot == '0))
    else $error("refused create carries a slot");

endmodule

bind software_timer_table_core sst_checker u_sst_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
